>>> rtl/hfrd_pkg.sv
`default_nettype none

package hfrd_pkg;

  localparam int MaxFrame = 256;
  localparam int CntW     = $clog2(MaxFrame);

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0] StartByte   = 8'hEE;
  localparam logic [7:0] TailFc      = 8'hFC;
  localparam logic [7:0] TailFf      = 8'hFF;
  localparam logic [7:0] CmdHmi      = 8'hB1;
  localparam logic [7:0] SubScreen   = 8'h01;
  localparam logic [7:0] SubEvent    = 8'h11;
  localparam logic [7:0] EvtKey      = 8'h10;
  localparam logic [7:0] EvtText     = 8'h11;

  // frame byte positions
  localparam int PosCmd     = 1;
  localparam int PosSub     = 2;
  localparam int PosScrHi   = 3;
  localparam int PosScrLo   = 4;
  localparam int PosCtlHi   = 5;
  localparam int PosCtlLo   = 6;
  localparam int PosEvt     = 7;
  localparam int PosTailMin = 3;
  localparam int FrameOvh   = 12;

  typedef enum logic [2:0] {
    KindPayload  = 3'd0,
    KindScreen   = 3'd1,
    KindKey      = 3'd2,
    KindText     = 3'd3,
    KindOther    = 3'd4,
    KindOverflow = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [15:0] page_id;
    logic [15:0] widget_id;
    logic [7:0]  payload_length;
    logic        frame_end;
  } result_t;

  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

`default_nettype wire

>>> rtl/hfrd_in_if.sv
`default_nettype none

interface hfrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/hfrd_out_if.sv
`default_nettype none

interface hfrd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic [15:0] page_id;
  logic [15:0] widget_id;
  logic [7:0]  payload_length;
  logic        frame_end;

  modport source (
    output valid, output result_kind, output data_byte, output byte_index,
    output page_id, output widget_id, output payload_length, output frame_end,
    input ready
  );
  modport sink (
    input valid, input result_kind, input data_byte, input byte_index,
    input page_id, input widget_id, input payload_length, input frame_end,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/hfrd_decode.sv
`default_nettype none

module hfrd_decode (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    rx_byte_i,
  output hfrd_pkg::push_t    push_o
);
  import hfrd_pkg::*;

  logic            recv_q, recv_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      win_q [4];
  logic [7:0]      win_d [4];
  logic [7:0]      cmd_q, cmd_d;
  logic [7:0]      sub_q, sub_d;
  logic [15:0]     scr_q, scr_d;
  logic [15:0]     ctl_q, ctl_d;
  logic [7:0]      evt_q, evt_d;

  logic [CntW:0]   j_plus;
  logic            is_event, is_pay, end_hit, ovf_hit, pay_hit;
  logic [7:0]      plen;
  result_t         sum_r, pay_r;

  assign j_plus = {1'b0, cnt_q} + (CntW + 1)'(1);

  always_comb begin
    recv_d = recv_q;
    cnt_d  = cnt_q;
    win_d  = win_q;
    cmd_d  = cmd_q;
    sub_d  = sub_q;
    scr_d  = scr_q;
    ctl_d  = ctl_q;
    evt_d  = evt_q;
    end_hit = 1'b0;
    ovf_hit = 1'b0;
    if (accept_i) begin
      if (!recv_q) begin
        if (rx_byte_i == StartByte) begin
          win_d  = '{8'h00, 8'h00, 8'h00, rx_byte_i};
          cmd_d  = '0;
          sub_d  = '0;
          scr_d  = '0;
          ctl_d  = '0;
          evt_d  = '0;
          recv_d = 1'b1;
          cnt_d  = CntW'(1);
        end
      end else begin
        unique case (cnt_q)
          CntW'(PosCmd):   cmd_d = rx_byte_i;
          CntW'(PosSub):   sub_d = rx_byte_i;
          CntW'(PosScrHi): scr_d = {rx_byte_i, scr_q[7:0]};
          CntW'(PosScrLo): scr_d = {scr_q[15:8], rx_byte_i};
          CntW'(PosCtlHi): ctl_d = {rx_byte_i, ctl_q[7:0]};
          CntW'(PosCtlLo): ctl_d = {ctl_q[15:8], rx_byte_i};
          CntW'(PosEvt):   evt_d = rx_byte_i;
          default: ;
        endcase
        end_hit = (cnt_q >= CntW'(PosTailMin)) && (win_q[2] == TailFc) &&
                  (win_q[3] == TailFf) && (rx_byte_i == TailFf);
        ovf_hit = !end_hit && (cnt_q == CntW'(MaxFrame - 1));
        win_d = '{win_q[1], win_q[2], win_q[3], rx_byte_i};
        cnt_d = j_plus[CntW-1:0];
        if (end_hit || ovf_hit) begin
          recv_d = 1'b0;
          cnt_d  = '0;
        end
      end
    end
  end

  assign is_event = (cmd_d == CmdHmi) && (sub_d == SubEvent);
  assign is_pay   = is_event && ((evt_d == EvtKey) || (evt_d == EvtText));
  assign pay_hit  = accept_i && recv_q && is_pay && (cnt_q >= CntW'(FrameOvh));
  assign plen     = (j_plus >= (CntW + 1)'(FrameOvh)) ?
                    8'(j_plus - (CntW + 1)'(FrameOvh)) : 8'h00;

  always_comb begin
    pay_r            = '0;
    pay_r.kind       = KindPayload;
    pay_r.data_byte  = win_q[0];
    pay_r.byte_index = 8'(cnt_q - CntW'(FrameOvh));

    sum_r           = '0;
    sum_r.frame_end = 1'b1;
    priority if (ovf_hit) begin
      sum_r.kind = KindOverflow;
    end else if ((cmd_d == CmdHmi) && (sub_d == SubScreen)) begin
      sum_r.kind    = KindScreen;
      sum_r.page_id = scr_d;
    end else if (is_pay) begin
      sum_r.kind           = (evt_d == EvtKey) ? KindKey : KindText;
      sum_r.page_id        = scr_d;
      sum_r.widget_id      = ctl_d;
      sum_r.payload_length = plen;
    end else begin
      sum_r.kind = KindOther;
    end
  end

  assign push_o.vld0 = pay_hit;
  assign push_o.r0   = pay_r;
  assign push_o.vld1 = end_hit || ovf_hit;
  assign push_o.r1   = sum_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_q <= 1'b0;
      cnt_q  <= '0;
      win_q  <= '{default: 8'h00};
      cmd_q  <= '0;
      sub_q  <= '0;
      scr_q  <= '0;
      ctl_q  <= '0;
      evt_q  <= '0;
    end else begin
      recv_q <= recv_d;
      cnt_q  <= cnt_d;
      win_q  <= win_d;
      cmd_q  <= cmd_d;
      sub_q  <= sub_d;
      scr_q  <= scr_d;
      ctl_q  <= ctl_d;
      evt_q  <= evt_d;
    end
  end

  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !recv_q) |-> (!push_o.vld0 && !push_o.vld1))
    else $error("result while hunting for start byte");

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.vld1 |=> (!recv_q && (cnt_q == '0)))
    else $error("frame summary did not return to idle");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CntW'(MaxFrame - 1)) && (recv_q || (cnt_q == '0)))
    else $error("byte count out of range");

endmodule

`default_nettype wire

>>> rtl/hfrd_out_fifo.sv
`default_nettype none

module hfrd_out_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hfrd_pkg::push_t   push_i,
  output logic                   room_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output hfrd_pkg::result_t      data_o
);
  import hfrd_pkg::*;

  result_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [FifoCntW-1:0] n_push;
  logic                pop;
  result_t             first;

  assign n_push = FifoCntW'(push_i.vld0) + FifoCntW'(push_i.vld1);
  assign first  = push_i.vld0 ? push_i.r0 : push_i.r1;
  assign pop    = valid_o && ready_i;

  assign room_o  = cnt_q <= FifoCntW'(FifoDepth - 2);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];

  assign wp_d  = wp_q + FifoPtrW'(n_push);
  assign rp_d  = rp_q + FifoPtrW'(pop);
  assign cnt_d = cnt_q + n_push - FifoCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (n_push != '0) begin
      mem_q[wp_q] <= first;
    end
    if (push_i.vld0 && push_i.vld1) begin
      mem_q[wp_q + FifoPtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push != '0) |-> room_o)
    else $error("write into full result queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("result queue count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != FifoCntW'(FifoDepth)) |->
      (FifoPtrW'(cnt_q) == FifoPtrW'(wp_q - rp_q)))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> rtl/hmi_frame_receiver_decoder_core.sv
`default_nettype none

// Channel | Dir | Beat contents
// rx_i    | in  | rx_byte: one received serial byte
// res_o   | out | result_kind, data_byte, byte_index, page_id, widget_id,
//         |     | payload_length, frame_end
//
// One byte is taken per cycle while rx_i.ready is high; its results are written
// into a four-entry result queue in the same cycle and can leave in the next cycle.
// A byte produces at most two results (a payload byte and a frame summary), so
// rx_i.ready drops while fewer than two queue entries are free. The queue drains
// one beat per cycle while res_o.ready is high; without output stalls the rate is
// one byte per cycle. Reset (rst_ni low, asynchronous) returns to hunting for the
// start byte and empties the queue.
module hmi_frame_receiver_decoder_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hfrd_in_if.sink    rx_i,
  hfrd_out_if.source res_o
);
  import hfrd_pkg::*;

  push_t   push;
  result_t head;
  logic    room;
  logic    accept;

  assign accept     = rx_i.valid && rx_i.ready;
  assign rx_i.ready = room;

  hfrd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .push_o    (push)
  );

  hfrd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (head)
  );

  assign res_o.result_kind    = head.kind;
  assign res_o.data_byte      = head.data_byte;
  assign res_o.byte_index     = head.byte_index;
  assign res_o.page_id        = head.page_id;
  assign res_o.widget_id      = head.widget_id;
  assign res_o.payload_length = head.payload_length;
  assign res_o.frame_end      = head.frame_end;

endmodule

`default_nettype wire
